// ===== hdl/oal_pkg.sv =====
// Shared types and constants for the ordered array list.
package oal_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 7;
    localparam int WORD_W       = 32;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_READ   = 3'd4,
        CMD_WRITE  = 3'd5,
        CMD_RESIZE = 3'd6,
        CMD_CLEAR  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_INSERT,
        OP_REMOVE,
        OP_ZERO
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [WORD_W-1:0]  value;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]                command;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_word;
        logic [POS_W-1:0]          item_count;
        logic                      is_empty;
        logic                      op_error;
    } t_out_beat;

endpackage

// ===== hdl/oal_cell.sv =====
// One storage cell of the list: holds one entry and trades words with its neighbors.
module oal_cell #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0,
    localparam int CW = ($clog2(CAPACITY + 1) > oal_pkg::POS_W) ?
                        $clog2(CAPACITY + 1) : oal_pkg::POS_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  oal_pkg::t_cell_ctl                i_ctl,
    input  logic [CW-1:0]                     i_tgt,
    input  logic [CW-1:0]                     i_cnt,
    input  logic [CW-1:0]                     i_rd_idx,
    input  logic signed [oal_pkg::WORD_W-1:0] i_left,
    input  logic signed [oal_pkg::WORD_W-1:0] i_right,
    output logic signed [oal_pkg::WORD_W-1:0] o_word,
    output logic signed [oal_pkg::WORD_W-1:0] o_rd
);

    localparam logic [CW:0] IDX = (CW + 1)'(INDEX);

    logic signed [oal_pkg::WORD_W-1:0] r_word;
    logic signed [oal_pkg::WORD_W-1:0] n_word;
    logic [CW:0]                       tgt;
    logic [CW:0]                       cnt;

    assign tgt = {1'b0, i_tgt};
    assign cnt = {1'b0, i_cnt};

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            oal_pkg::OP_LOAD: begin
                if (IDX == tgt) n_word = i_ctl.value;
            end
            oal_pkg::OP_INSERT: begin
                if (IDX == tgt) n_word = i_ctl.value;
                else if (IDX > tgt && IDX <= cnt) n_word = i_left;
            end
            oal_pkg::OP_REMOVE: begin
                if (IDX >= tgt && IDX + 1'b1 < cnt) n_word = i_right;
            end
            oal_pkg::OP_ZERO: begin
                if (IDX >= cnt && IDX < tgt) n_word = '0;
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
    assign o_rd   = (IDX == {1'b0, i_rd_idx}) ? r_word : '0;

endmodule

// ===== hdl/ordered_array_list.sv =====
// Top level of the ordered array list: command decode, count, cell row and output register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_beat)
//
// Every command completes in the cycle its beat is accepted; the result beat appears in
// the next cycle, so one command per cycle is sustained unless the output stalls. All cells shift together.
// Reset clears the count and every cell to zero.
// The input stalls only while a result beat waits and the output is stalled.
module ordered_array_list #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  oal_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output oal_pkg::t_out_beat o_out_data
);

    localparam int CW = ($clog2(CAPACITY + 1) > oal_pkg::POS_W) ?
                        $clog2(CAPACITY + 1) : oal_pkg::POS_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;
    logic                               r_out_valid;
    oal_pkg::t_out_beat                 r_out;
    oal_pkg::t_out_beat                 n_out;
    logic                               accept;
    logic [CW-1:0]                      pos;
    logic [CW-1:0]                      rd_idx;
    logic                               err;
    oal_pkg::t_cell_ctl                 ctl;
    logic signed [oal_pkg::WORD_W-1:0]  words [CAPACITY];
    logic signed [oal_pkg::WORD_W-1:0]  rds   [CAPACITY];
    logic signed [oal_pkg::WORD_W-1:0]  rd_word;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign pos        = CW'(i_in_data.position);
    assign rd_idx     = (pos < r_count) ? pos : '0;

    always_comb begin
        ctl.op    = oal_pkg::OP_NONE;
        ctl.value = i_in_data.value;
        err       = 1'b0;
        n_count   = r_count;
        case (oal_pkg::t_cmd'(i_in_data.command))
            oal_pkg::CMD_PUSH: begin
                if (r_count >= CAP) begin
                    err = 1'b1;
                end else begin
                    ctl.op  = oal_pkg::OP_LOAD;
                    n_count = r_count + 1'b1;
                end
            end
            oal_pkg::CMD_POP: begin
                if (r_count != '0) n_count = r_count - 1'b1;
            end
            oal_pkg::CMD_INSERT: begin
                if (r_count >= CAP || pos > r_count) begin
                    err = 1'b1;
                end else begin
                    ctl.op  = oal_pkg::OP_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            oal_pkg::CMD_REMOVE: begin
                if (pos >= r_count) begin
                    err = 1'b1;
                end else begin
                    ctl.op  = oal_pkg::OP_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            oal_pkg::CMD_READ: begin
                ctl.op = oal_pkg::OP_NONE;
            end
            oal_pkg::CMD_WRITE: begin
                if (pos >= r_count) err = 1'b1;
                else ctl.op = oal_pkg::OP_LOAD;
            end
            oal_pkg::CMD_RESIZE: begin
                if (pos > CAP) begin
                    err = 1'b1;
                end else begin
                    ctl.op  = oal_pkg::OP_ZERO;
                    n_count = pos;
                end
            end
            oal_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // The push target is the current count; every other command targets the position.
    logic [CW-1:0] tgt;
    assign tgt = (oal_pkg::t_cmd'(i_in_data.command) == oal_pkg::CMD_PUSH) ? r_count : pos;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [oal_pkg::WORD_W-1:0] left;
        logic signed [oal_pkg::WORD_W-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = words[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = words[g];
        end else begin : g_mid_r
            assign right = words[g+1];
        end
        oal_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (accept),
            .i_ctl    (ctl),
            .i_tgt    (tgt),
            .i_cnt    (r_count),
            .i_rd_idx (rd_idx),
            .i_left   (left),
            .i_right  (right),
            .o_word   (words[g]),
            .o_rd     (rds[g])
        );
    end

    always_comb begin
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_word = rd_word | rds[k];
        end
    end

    always_comb begin
        n_out.read_word  = (oal_pkg::t_cmd'(i_in_data.command) == oal_pkg::CMD_READ) ?
                           rd_word : '0;
        n_out.item_count = n_count[oal_pkg::POS_W-1:0];
        n_out.is_empty   = (n_count == '0);
        n_out.op_error   = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
